// ----- hdl/efesp_pkg.sv -----
// Shared types, constants and control structs for the exFAT entry set parser.
package efesp_pkg;

    localparam int ENTRY_BYTES          = 32;
    localparam int IDX_W                = $clog2(ENTRY_BYTES);
    localparam int NAME_CAPACITY        = 260;
    localparam int NAME_W               = 9;
    localparam int NAME_BYTES_PER_ENTRY = 30;
    localparam int K_W                  = $clog2(NAME_BYTES_PER_ENTRY);
    localparam int TALLY_W              = 9;

    localparam int OFS_TYPE       = 0;
    localparam int OFS_SECOND     = 1;
    localparam int OFS_ATTR       = 4;
    localparam int OFS_CLUSTER    = 20;
    localparam int OFS_LENGTH     = 24;
    localparam int NAME_FIRST_BYTE = 2;

    localparam logic [7:0] TYPE_FILE   = 8'h85;
    localparam logic [7:0] TYPE_STREAM = 8'hC0;
    localparam logic [7:0] TYPE_NAME   = 8'hC1;

    localparam logic KIND_NAME = 1'b0;
    localparam logic KIND_INFO = 1'b1;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       region_end;
    } t_in;

    typedef struct packed {
        logic              record_kind;
        logic [NAME_W-1:0] name_position;
        logic [7:0]        name_char;
        logic              set_complete;
        logic [7:0]        secondary_total;
        logic [15:0]       file_attributes;
        logic [31:0]       start_cluster;
        logic [7:0]        chain_flags;
        logic [63:0]       byte_length;
        logic [NAME_W-1:0] name_length;
        logic              name_truncated;
        logic              last_of_run;
    } t_out;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_NAME_RD,
        ST_NAME_OUT,
        ST_WRAP,
        ST_INFO
    } t_state;

    typedef struct packed {
        logic accept;
        logic decode;
        logic name_rd;
        logic name_skip;
        logic name_emit;
        logic info_load;
    } t_cmd;

    typedef struct packed {
        logic entry_last;
        logic in_end;
        logic is_name;
        logic name_room;
        logic k_last;
        logic out_free;
        logic info_pend;
    } t_stat;

endpackage

// ----- hdl/efesp_dpath.sv -----
// Datapath: entry store, field capture, set state and output register.
module efesp_dpath (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  efesp_pkg::t_cmd  i_cmd,
    output efesp_pkg::t_stat o_stat,
    input  efesp_pkg::t_in   i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output efesp_pkg::t_out  o_out_data
);
    import efesp_pkg::*;

    logic [7:0]                r_mem [ENTRY_BYTES];
    logic [IDX_W-1:0]          r_byte_idx;
    logic [7:0]                r_type;
    logic [7:0]                r_second;
    logic [15:0]               r_attr_raw;
    logic [31:0]               r_clus_raw;
    logic [63:0]               r_len_raw;
    logic                      r_region_end;
    logic                      r_done;
    logic signed [TALLY_W-1:0] r_tally;
    logic [7:0]                r_count;
    logic [15:0]               r_attr;
    logic [31:0]               r_cluster;
    logic [7:0]                r_flags;
    logic [63:0]               r_length;
    logic [NAME_W-1:0]         r_name_fill;
    logic                      r_overflow;
    logic [K_W-1:0]            r_k;
    logic [7:0]                r_rd_data;
    logic                      r_out_valid;
    t_out                      r_out;

    logic signed [TALLY_W-1:0] n_tally;
    logic [7:0]                n_count;
    logic                      w_done;
    logic [IDX_W-1:0]          w_rd_addr;
    logic                      w_out_free;
    logic                      w_info_pend;
    logic                      w_name_last;
    t_out                      w_name_rec;
    t_out                      w_info_rec;

    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_info_pend = r_done || r_region_end;
    assign w_rd_addr   = IDX_W'(r_k) + IDX_W'(NAME_FIRST_BYTE);
    assign w_name_last = !w_info_pend &&
                         (r_k == K_W'(NAME_BYTES_PER_ENTRY - 1) ||
                          ({1'b0, r_name_fill} + (NAME_W + 1)'(1)) >=
                          (NAME_W + 1)'(NAME_CAPACITY));

    always_comb begin
        n_tally = r_tally;
        n_count = r_count;
        case (r_type) inside
            TYPE_FILE: begin
                n_tally = '0;
                n_count = r_second;
            end
            TYPE_STREAM, TYPE_NAME: begin
                n_tally = r_tally + TALLY_W'(1);
            end
            default: begin
            end
        endcase
        w_done = n_tally >= $signed({1'b0, n_count});
    end

    always_comb begin
        w_name_rec               = '0;
        w_name_rec.record_kind   = KIND_NAME;
        w_name_rec.name_position = r_name_fill;
        w_name_rec.name_char     = r_rd_data;
        w_name_rec.last_of_run   = w_name_last;

        w_info_rec                 = '0;
        w_info_rec.record_kind     = KIND_INFO;
        w_info_rec.set_complete    = r_done;
        w_info_rec.secondary_total = r_count;
        w_info_rec.file_attributes = r_attr;
        w_info_rec.start_cluster   = r_cluster;
        w_info_rec.chain_flags     = r_flags;
        w_info_rec.byte_length     = r_length;
        w_info_rec.name_length     = r_name_fill;
        w_info_rec.name_truncated  = r_overflow;
        w_info_rec.last_of_run     = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_mem[r_byte_idx] <= i_in_data.data_byte;
            case (r_byte_idx) inside
                IDX_W'(OFS_TYPE): begin
                    r_type <= i_in_data.data_byte;
                end
                IDX_W'(OFS_SECOND): begin
                    r_second <= i_in_data.data_byte;
                end
                [IDX_W'(OFS_ATTR) : IDX_W'(OFS_ATTR + 1)]: begin
                    r_attr_raw[{r_byte_idx[0], 3'b000} +: 8] <= i_in_data.data_byte;
                end
                [IDX_W'(OFS_CLUSTER) : IDX_W'(OFS_CLUSTER + 3)]: begin
                    r_clus_raw[{r_byte_idx[1:0], 3'b000} +: 8] <= i_in_data.data_byte;
                end
                [IDX_W'(OFS_LENGTH) : IDX_W'(OFS_LENGTH + 7)]: begin
                    r_len_raw[{r_byte_idx[2:0], 3'b000} +: 8] <= i_in_data.data_byte;
                end
                default: begin
                end
            endcase
        end
        if (i_cmd.name_rd) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
        if (i_cmd.name_emit) begin
            r_out <= w_name_rec;
        end else if (i_cmd.info_load) begin
            r_out <= w_info_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_idx   <= '0;
            r_region_end <= 1'b0;
            r_done       <= 1'b0;
            r_tally      <= '1;
            r_count      <= '0;
            r_attr       <= '0;
            r_cluster    <= '0;
            r_flags      <= '0;
            r_length     <= '0;
            r_name_fill  <= '0;
            r_overflow   <= 1'b0;
            r_k          <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                r_byte_idx   <= i_in_data.region_end ? '0 : r_byte_idx + IDX_W'(1);
                r_region_end <= i_in_data.region_end;
                r_done       <= 1'b0;
            end
            if (i_cmd.decode) begin
                r_tally <= n_tally;
                r_count <= n_count;
                r_done  <= w_done;
                r_k     <= '0;
                if (r_type == TYPE_FILE) begin
                    r_attr <= r_attr_raw;
                end
                if (r_type == TYPE_STREAM) begin
                    r_flags   <= r_second;
                    r_cluster <= r_clus_raw;
                    r_length  <= r_len_raw;
                end
            end
            if (i_cmd.name_skip) begin
                r_overflow <= 1'b1;
                r_k        <= r_k + K_W'(1);
            end
            if (i_cmd.name_emit) begin
                r_name_fill <= r_name_fill + NAME_W'(1);
                r_k         <= r_k + K_W'(1);
            end
            if (i_cmd.info_load) begin
                r_tally     <= '1;
                r_count     <= '0;
                r_attr      <= '0;
                r_cluster   <= '0;
                r_flags     <= '0;
                r_length    <= '0;
                r_name_fill <= '0;
                r_overflow  <= 1'b0;
            end
            if (i_cmd.name_emit || i_cmd.info_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.entry_last = r_byte_idx == IDX_W'(ENTRY_BYTES - 1);
    assign o_stat.in_end     = i_in_data.region_end;
    assign o_stat.is_name    = r_type == TYPE_NAME;
    assign o_stat.name_room  = r_name_fill < NAME_W'(NAME_CAPACITY);
    assign o_stat.k_last     = r_k == K_W'(NAME_BYTES_PER_ENTRY - 1);
    assign o_stat.out_free   = w_out_free;
    assign o_stat.info_pend  = w_info_pend;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ----- hdl/efesp_ctrl.sv -----
// Controller: state machine that sequences byte intake, decode, name beats and info beats.
module efesp_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  efesp_pkg::t_stat i_stat,
    output efesp_pkg::t_cmd  o_cmd,
    output logic             o_in_stall
);
    import efesp_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_stat.entry_last) begin
                        n_state = ST_DECODE;
                    end else if (i_stat.in_end) begin
                        n_state = ST_INFO;
                    end
                end
            end
            ST_DECODE: begin
                n_state = i_stat.is_name ? ST_NAME_RD : ST_WRAP;
            end
            ST_NAME_RD: begin
                if (i_stat.name_room) begin
                    n_state = ST_NAME_OUT;
                end else if (i_stat.k_last) begin
                    n_state = ST_WRAP;
                end
            end
            ST_NAME_OUT: begin
                if (i_stat.out_free) begin
                    n_state = i_stat.k_last ? ST_WRAP : ST_NAME_RD;
                end
            end
            ST_WRAP: begin
                n_state = i_stat.info_pend ? ST_INFO : ST_IDLE;
            end
            ST_INFO: begin
                if (i_stat.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_in_stall   = 1'b0;
                o_cmd.accept = i_in_valid;
            end
            ST_DECODE: begin
                o_cmd.decode = 1'b1;
            end
            ST_NAME_RD: begin
                o_cmd.name_rd   = i_stat.name_room;
                o_cmd.name_skip = !i_stat.name_room;
            end
            ST_NAME_OUT: begin
                o_cmd.name_emit = i_stat.out_free;
            end
            ST_WRAP: begin
            end
            ST_INFO: begin
                o_cmd.info_load = i_stat.out_free;
            end
            default: begin
            end
        endcase
    end

endmodule

// ----- hdl/exfat_entry_set_parser.sv -----
// Top level: exFAT directory entry set parser, bytes in, name and info records out.
// A byte that completes no entry and does not end the region is taken back to back, one byte per cycle.
// A completed entry holds off input through decode and wrap, plus a store read and an output load per
// emitted name byte and a skip per dropped one, plus the info record load when a record is due.
// Output stalls stretch the output load and info beats.
// Reset is synchronous, active low; it clears control and set state, the entry store is not cleared.
module exfat_entry_set_parser (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  efesp_pkg::t_in  i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output efesp_pkg::t_out o_out_data
);
    import efesp_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    efesp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd),
        .o_in_stall (o_in_stall)
    );

    efesp_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.name_emit || w_cmd.info_load) |-> w_stat.out_free)
        else $error("output register loaded while a beat is stalled");

    a_name_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.record_kind == KIND_NAME) |->
        (o_out_data.name_position < NAME_W'(NAME_CAPACITY)))
        else $error("name beat position beyond capacity");

    a_info_frees_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.info_load |=> !o_in_stall)
        else $error("input not released after info beat");

endmodule

// ----- tb/efesp_checker.sv -----
// Checker for the exFAT entry set parser: predicts records from input beats and compares.
`timescale 1ns / 100ps

module efesp_checker (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_in_stall,
    input  efesp_pkg::t_in  i_in_data,
    input  logic            i_out_valid,
    input  logic            i_out_stall,
    input  efesp_pkg::t_out i_out_data,
    output int              o_fail_count,
    output int              o_pending
);
    import efesp_pkg::*;

    t_out        expected_records[$];
    int          mismatch_total = 0;

    logic [7:0]  entry_bytes [ENTRY_BYTES];
    int          byte_idx;
    int          tally;
    logic [7:0]  count_held;
    logic [15:0] attr_held;
    logic [31:0] cluster_held;
    logic [7:0]  flags_held;
    logic [63:0] length_held;
    int          name_fill;
    logic        name_over;

    task automatic new_set();
        tally        = -1;
        count_held   = '0;
        attr_held    = '0;
        cluster_held = '0;
        flags_held   = '0;
        length_held  = '0;
        name_fill    = 0;
        name_over    = 1'b0;
    endtask

    task automatic predict_beat(input t_in beat);
        t_out run_recs[$];
        t_out rec;
        logic set_done;
        entry_bytes[byte_idx] = beat.data_byte;
        set_done = 1'b0;
        if (byte_idx == ENTRY_BYTES - 1) begin
            byte_idx = 0;
            case (entry_bytes[OFS_TYPE])
                TYPE_FILE: begin
                    tally      = 0;
                    count_held = entry_bytes[OFS_SECOND];
                    attr_held  = {entry_bytes[OFS_ATTR + 1], entry_bytes[OFS_ATTR]};
                end
                TYPE_STREAM: begin
                    flags_held = entry_bytes[OFS_SECOND];
                    for (int j = 3; j >= 0; j--)
                        cluster_held = {cluster_held[23:0], entry_bytes[OFS_CLUSTER + j]};
                    for (int j = 7; j >= 0; j--)
                        length_held = {length_held[55:0], entry_bytes[OFS_LENGTH + j]};
                    tally++;
                end
                TYPE_NAME: begin
                    for (int j = 0; j < NAME_BYTES_PER_ENTRY; j++) begin
                        if (name_fill < NAME_CAPACITY) begin
                            rec               = '0;
                            rec.record_kind   = KIND_NAME;
                            rec.name_position = NAME_W'(name_fill);
                            rec.name_char     = entry_bytes[NAME_FIRST_BYTE + j];
                            run_recs.push_back(rec);
                            name_fill++;
                        end else begin
                            name_over = 1'b1;
                        end
                    end
                    tally++;
                end
                default: ;
            endcase
            set_done = (tally >= int'(count_held));
        end else begin
            byte_idx++;
        end

        if (set_done || beat.region_end) begin
            rec                 = '0;
            rec.record_kind     = KIND_INFO;
            rec.set_complete    = set_done;
            rec.secondary_total = count_held;
            rec.file_attributes = attr_held;
            rec.start_cluster   = cluster_held;
            rec.chain_flags     = flags_held;
            rec.byte_length     = length_held;
            rec.name_length     = NAME_W'(name_fill);
            rec.name_truncated  = name_over;
            run_recs.push_back(rec);
            new_set();
            if (beat.region_end) begin
                byte_idx = 0;
            end
        end

        if (run_recs.size() > 0) begin
            rec = run_recs.pop_back();
            rec.last_of_run = 1'b1;
            run_recs.push_back(rec);
        end
        foreach (run_recs[j])
            expected_records.push_back(run_recs[j]);
    endtask

    task automatic check_field(input string fname, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, actual 0x%0h", fname, want, got);
            mismatch_total++;
        end
    endtask

    task automatic compare_record(input t_out want, input t_out got);
        check_field("record_kind",     want.record_kind,     got.record_kind);
        check_field("name_position",   want.name_position,   got.name_position);
        check_field("name_char",       want.name_char,       got.name_char);
        check_field("set_complete",    want.set_complete,    got.set_complete);
        check_field("secondary_total", want.secondary_total, got.secondary_total);
        check_field("file_attributes", want.file_attributes, got.file_attributes);
        check_field("start_cluster",   want.start_cluster,   got.start_cluster);
        check_field("chain_flags",     want.chain_flags,     got.chain_flags);
        check_field("byte_length",     want.byte_length,     got.byte_length);
        check_field("name_length",     want.name_length,     got.name_length);
        check_field("name_truncated",  want.name_truncated,  got.name_truncated);
        check_field("last_of_run",     want.last_of_run,     got.last_of_run);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            expected_records.delete();
            byte_idx = 0;
            new_set();
            o_pending <= 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_records.size() == 0) begin
                    $error("record_kind: expected none, actual 0x%0h",
                           i_out_data.record_kind);
                    mismatch_total++;
                end else begin
                    compare_record(expected_records.pop_front(), i_out_data);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                predict_beat(i_in_data);
            end
            o_pending <= expected_records.size();
        end
        o_fail_count <= mismatch_total;
    end

endmodule

// ----- tb/tb_exfat_entry_set_parser.sv -----
// Testbench top for the exFAT entry set parser: stimulus, handshake idling and verdict.
`timescale 1ns / 100ps

module tb_exfat_entry_set_parser;
    import efesp_pkg::*;

    localparam int RANDOM_BEATS = 60;
    localparam int STALL_LIMIT  = 5000;

    logic  clk;
    logic  rst_n;
    logic  in_valid;
    logic  in_stall;
    t_in   in_data;
    logic  out_valid;
    logic  out_stall;
    t_out  out_data;
    int    fail_count;
    int    pending_records;

    logic  idle_on = 1'b1;
    int    beats_sent = 0;
    int    quiet_cycles = 0;
    logic [7:0] entry_buf [ENTRY_BYTES];

    exfat_entry_set_parser u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    efesp_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending_records)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        out_stall <= 1'b0;
        forever begin
            @(posedge clk);
            if (idle_on && $urandom_range(0, 7) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic push_beat(input logic [7:0] value, input logic last_in_region);
        if (idle_on && $urandom_range(0, 7) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{data_byte: value, region_end: last_in_region};
        do @(posedge clk); while (in_stall);
        beats_sent++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_records != 0);
    endtask

    // cut_at < 0 sends the whole entry; otherwise stop at that byte with region end
    task automatic send_entry(input int cut_at);
        for (int j = 0; j < ENTRY_BYTES; j++) begin
            if (j == cut_at) begin
                push_beat(entry_buf[j], 1'b1);
                return;
            end
            push_beat(entry_buf[j], 1'b0);
        end
    endtask

    task automatic fill_random();
        for (int j = 0; j < ENTRY_BYTES; j++)
            entry_buf[j] = 8'($urandom);
    endtask

    task automatic fill_file(input logic [7:0] count, input logic [15:0] attr);
        fill_random();
        entry_buf[OFS_TYPE]     = TYPE_FILE;
        entry_buf[OFS_SECOND]   = count;
        entry_buf[OFS_ATTR]     = attr[7:0];
        entry_buf[OFS_ATTR + 1] = attr[15:8];
    endtask

    task automatic fill_stream(input logic [7:0] flags, input logic [31:0] cluster,
                               input logic [63:0] length);
        fill_random();
        entry_buf[OFS_TYPE]   = TYPE_STREAM;
        entry_buf[OFS_SECOND] = flags;
        for (int j = 0; j < 4; j++)
            entry_buf[OFS_CLUSTER + j] = cluster[8*j +: 8];
        for (int j = 0; j < 8; j++)
            entry_buf[OFS_LENGTH + j] = length[8*j +: 8];
    endtask

    task automatic fill_name();
        fill_random();
        entry_buf[OFS_TYPE] = TYPE_NAME;
    endtask

    task automatic send_noise();
        int len;
        len = $urandom_range(1, 40);
        for (int j = 1; j <= len; j++)
            push_beat(8'($urandom), (j == len) || ($urandom_range(0, 15) == 0));
    endtask

    task automatic send_random_set();
        int count;
        int n_sec;
        int cut_sec;
        count   = ($urandom_range(0, 5) == 0) ? int'($urandom_range(4, 255))
                                              : int'($urandom_range(0, 3));
        n_sec   = (count > 3) ? int'($urandom_range(1, 3)) : count;
        cut_sec = ($urandom_range(0, 4) == 0) ? int'($urandom_range(0, n_sec)) : -1;
        fill_file(8'(count), 16'($urandom));
        if (cut_sec == 0) begin
            send_entry(int'($urandom_range(0, ENTRY_BYTES - 1)));
            return;
        end
        send_entry(-1);
        for (int s = 1; s <= n_sec; s++) begin
            case ($urandom_range(0, 9))
                0:       fill_random();
                1, 2, 3: fill_stream(8'($urandom), $urandom, {$urandom, $urandom});
                default: fill_name();
            endcase
            if (s == cut_sec) begin
                send_entry(int'($urandom_range(0, ENTRY_BYTES - 1)));
                return;
            end
            if (s == n_sec && (count > n_sec || $urandom_range(0, 3) == 0)) begin
                send_entry(ENTRY_BYTES - 1);
            end else begin
                send_entry(-1);
            end
        end
    endtask

    initial begin
        int random_start;
        int progress;
        logic paused_mid;

        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        in_data  <= '0;
        paused_mid = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // region end on a lone byte
        push_beat(8'hFF, 1'b1);
        // secondary with no file entry open, extreme field values
        fill_stream(8'hFF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        send_entry(-1);
        // name longer than capacity, set closed by a partial entry at region end
        fill_file(8'd10, 16'hFFFF);
        send_entry(-1);
        fill_name();
        for (int j = NAME_FIRST_BYTE; j < ENTRY_BYTES; j++)
            entry_buf[j] = j[0] ? 8'hFF : 8'h00;
        send_entry(-1);
        repeat (8) begin
            fill_name();
            send_entry(-1);
        end
        fill_name();
        send_entry(7);
        // set completes on the region's last byte
        fill_file(8'd1, 16'($urandom));
        send_entry(-1);
        fill_name();
        send_entry(ENTRY_BYTES - 1);

        wait_drained();

        random_start = beats_sent;
        while (beats_sent - random_start < RANDOM_BEATS) begin
            progress = beats_sent - random_start;
            idle_on = !((progress > RANDOM_BEATS * 2 / 5 && progress < RANDOM_BEATS * 11 / 20)
                        || progress > RANDOM_BEATS * 17 / 20);
            if (!paused_mid && progress > RANDOM_BEATS / 2) begin
                wait_drained();
                paused_mid = 1'b1;
            end
            if ($urandom_range(0, 4) == 0) begin
                send_noise();
            end else begin
                send_random_set();
            end
        end

        idle_on = 1'b0;
        wait_drained();
        repeat (80) @(posedge clk);
        if (fail_count == 0 && pending_records == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hdl/efesp_pkg.sv
hdl/efesp_dpath.sv
hdl/efesp_ctrl.sv
hdl/exfat_entry_set_parser.sv
tb/efesp_checker.sv
tb/tb_exfat_entry_set_parser.sv
